/* rtl/core/pulse_width_bit_symbol_decoder_core_defines.svh */
// assertion macros used by the checker file of the decoder core
`ifndef PULSE_WIDTH_BIT_SYMBOL_DECODER_CORE_DEFINES_SVH
`define PULSE_WIDTH_BIT_SYMBOL_DECODER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PWBSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define PWBSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also checks across reset
`define PWBSD_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pwbsd_pkg.sv */
package pwbsd_pkg;

    // field widths
    localparam int UNIT_W       = 12;
    localparam int SYM_W        = 2;
    localparam int OUT_STAMP_W  = 32;

    // channel widths
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 2 * OUT_STAMP_W;
    localparam int M_TUSER_W    = SYM_W;

    // parameter defaults
    localparam int STAMP_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    // unit register after reset
    localparam logic [UNIT_W-1:0] UNIT_RESET = 12'd4;

    // symbol codes
    typedef enum logic [SYM_W-1:0] {
        SYM_ZERO       = 2'd0,
        SYM_ONE        = 2'd1,
        SYM_CONSOLE    = 2'd2,
        SYM_CONTROLLER = 2'd3
    } symbol_t;

endpackage

/* rtl/core/pulse_width_bit_symbol_decoder_core.sv */
// Pulse-width bit symbol decoder for an idle-high single-wire line. Each item on the
// s_ side is one line sample (s_tdata[0]); the core accepts one sample per clock and a
// decoded symbol appears in the output register in the cycle after the sample that ends it.
// Rounding of the low and high phases uses thresholds of odd multiples of the unit,
// held in registers that are reloaded on each cfg_wr_en write of cfg_wr_data (a value of zero acts
// as one sample per unit). s_tready only drops while a finished symbol sits in the output
// register and m_tready is low; that single output register sets the one-item-per-cycle
// rate. Results carry the symbol code in m_tuser and the start and end sample stamps in
// m_tdata, stamps wrapping at the low 32 bits.
module pulse_width_bit_symbol_decoder_core #(
    parameter int STAMP_WIDTH = pwbsd_pkg::STAMP_WIDTH_DEF,
    parameter int COUNT_WIDTH = pwbsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: unit_samples
    input  logic                            cfg_wr_en,
    input  logic [pwbsd_pkg::UNIT_W-1:0]    cfg_wr_data,
    // sample in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pwbsd_pkg::S_TDATA_W-1:0] s_tdata,   // [0] line_level, rest zero
    // symbol out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pwbsd_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] start_stamp, [63:32] end_stamp
    output logic [pwbsd_pkg::M_TUSER_W-1:0] m_tuser    // [1:0] symbol
);

    localparam int UW  = pwbsd_pkg::UNIT_W;
    localparam int OSW = pwbsd_pkg::OUT_STAMP_W;
    // thresholds reach 13 units and are compared with twice a count
    localparam int TH_W = (COUNT_WIDTH + 1 > UW + 4) ? COUNT_WIDTH + 1 : UW + 4;
    localparam logic [TH_W-1:0] COUNT_MAX_TH = TH_W'({COUNT_WIDTH{1'b1}});

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    typedef logic [7:1][TH_W-1:0]        th_arr_t;
    typedef logic [3:1][COUNT_WIDTH-1:0] cap_arr_t;

    // rounded units, ties to even, saturating at seven
    function automatic logic [2:0] round_units(input logic [COUNT_WIDTH-1:0] len,
                                               input th_arr_t th);
        logic [TH_W-1:0] len2;
        logic [2:0]      n;
        len2 = TH_W'(len) << 1;
        n    = 3'd0;
        for (int k = 1; k <= 7; k++) begin
            if (((k & 1) == 0) ? (len2 >= th[k]) : (len2 > th[k])) begin
                n = n + 3'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // rounding thresholds for a unit value
    function automatic th_arr_t make_th(input logic [UW-1:0] u);
        th_arr_t t;
        for (int k = 1; k <= 7; k++) begin
            t[k] = TH_W'(u) * TH_W'(2 * k - 1);
        end
        return t;
    endfunction

    // high phase caps for one, two and three low units
    function automatic cap_arr_t make_cap(input logic [UW-1:0] u);
        cap_arr_t        c;
        logic [TH_W-1:0] lim;
        for (int k = 1; k <= 3; k++) begin
            lim  = TH_W'(u) * TH_W'(4 - k);
            c[k] = (lim < COUNT_MAX_TH) ? COUNT_WIDTH'(lim) : {COUNT_WIDTH{1'b1}};
        end
        return c;
    endfunction

    // configuration state
    logic [UW-1:0]           unit_reg;
    logic [UW-1:0]           unit_next;
    th_arr_t                 th_reg;
    cap_arr_t                caps_reg;

    // decoder state
    phase_t                  phase_reg, phase_next;
    logic                    last_level_reg, last_level_next;
    logic [STAMP_WIDTH-1:0]  idx_reg, idx_next;
    logic [COUNT_WIDTH-1:0]  low_len_reg, low_len_next;
    logic [COUNT_WIDTH-1:0]  high_len_reg, high_len_next;
    logic [2:0]              low_units_reg, low_units_next;
    logic [COUNT_WIDTH-1:0]  cap_reg, cap_next;
    logic [STAMP_WIDTH-1:0]  fall_stamp_reg, fall_stamp_next;

    // output register
    logic                    m_valid_reg;
    pwbsd_pkg::symbol_t      m_sym_reg, m_sym_next;
    logic [OSW-1:0]          m_start_reg, m_start_next;
    logic [OSW-1:0]          m_end_reg, m_end_next;

    logic                    s_fire;
    logic                    lvl;
    logic                    sym_valid;
    logic [2:0]              low_units_now;
    logic [COUNT_WIDTH-1:0]  high_inc;
    logic [2:0]              high_units;
    logic [STAMP_WIDTH-1:0]  end_stamp;
    logic [STAMP_WIDTH+OSW-1:0] fall_ext;
    logic [STAMP_WIDTH+OSW-1:0] end_ext;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign lvl      = s_tdata[0];

    assign unit_next = (cfg_wr_data == '0) ? UW'(1) : cfg_wr_data;

    // next state for one accepted sample
    always_comb begin
        phase_next      = phase_reg;
        low_len_next    = low_len_reg;
        high_len_next   = high_len_reg;
        low_units_next  = low_units_reg;
        cap_next        = cap_reg;
        fall_stamp_next = fall_stamp_reg;
        sym_valid       = 1'b0;
        m_sym_next      = pwbsd_pkg::SYM_ZERO;
        end_stamp       = idx_reg;

        low_units_now = round_units(low_len_reg, th_reg);
        high_inc      = sat_inc(high_len_reg);
        high_units    = round_units(high_inc, th_reg);

        unique case (phase_reg)
            PH_LOW: begin
                if (lvl) begin
                    low_units_next = low_units_now;
                    if (low_units_now >= 3'd1 && low_units_now <= 3'd3) begin
                        high_len_next = '0;
                        cap_next      = caps_reg[low_units_now[1:0]];
                        phase_next    = PH_HIGH;
                    end else begin
                        phase_next = PH_WAIT;
                    end
                end else begin
                    low_len_next = sat_inc(low_len_reg);
                end
            end
            PH_HIGH: begin
                high_len_next = high_inc;
                if (!lvl || high_inc >= cap_reg) begin
                    // classify low/high unit pair
                    priority if (low_units_reg == 3'd1 && high_units == 3'd3) begin
                        sym_valid  = 1'b1;
                        m_sym_next = pwbsd_pkg::SYM_ONE;
                    end else if (low_units_reg == 3'd3 && high_units == 3'd1) begin
                        sym_valid  = 1'b1;
                        m_sym_next = pwbsd_pkg::SYM_ZERO;
                    end else if (low_units_reg == 3'd1 && high_units == 3'd2) begin
                        sym_valid  = 1'b1;
                        m_sym_next = pwbsd_pkg::SYM_CONSOLE;
                    end else if (low_units_reg == 3'd2 &&
                                 (high_units == 3'd1 || high_units == 3'd2)) begin
                        sym_valid  = 1'b1;
                        m_sym_next = pwbsd_pkg::SYM_CONTROLLER;
                        if (high_units == 3'd2) begin
                            end_stamp = idx_reg - STAMP_WIDTH'(unit_reg);
                        end
                    end else begin
                        sym_valid = 1'b0;
                    end
                    if (!lvl) begin
                        fall_stamp_next = idx_reg;
                        low_len_next    = COUNT_WIDTH'(1);
                        phase_next      = PH_LOW;
                    end else begin
                        phase_next = PH_WAIT;
                    end
                end
            end
            default: begin
                // waiting for a falling edge
                if (last_level_reg && !lvl) begin
                    fall_stamp_next = idx_reg;
                    low_len_next    = COUNT_WIDTH'(1);
                    phase_next      = PH_LOW;
                end else begin
                    phase_next = PH_WAIT;
                end
            end
        endcase

        last_level_next = lvl;
        idx_next        = idx_reg + STAMP_WIDTH'(1);
    end

    // stamps to the output width
    assign fall_ext     = {{OSW{1'b0}}, fall_stamp_reg};
    assign end_ext      = {{OSW{1'b0}}, end_stamp};
    assign m_start_next = fall_ext[OSW-1:0];
    assign m_end_next   = end_ext[OSW-1:0];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= pwbsd_pkg::UNIT_RESET;
            th_reg   <= make_th(pwbsd_pkg::UNIT_RESET);
            caps_reg <= make_cap(pwbsd_pkg::UNIT_RESET);
        end else if (cfg_wr_en) begin
            unit_reg <= unit_next;
            th_reg   <= make_th(unit_next);
            caps_reg <= make_cap(unit_next);
        end
    end

    // decoder state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT;
            last_level_reg <= 1'b1;
            idx_reg        <= '0;
            low_len_reg    <= '0;
            high_len_reg   <= '0;
            low_units_reg  <= '0;
            cap_reg        <= '0;
            fall_stamp_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg      <= phase_next;
                last_level_reg <= last_level_next;
                idx_reg        <= idx_next;
                low_len_reg    <= low_len_next;
                high_len_reg   <= high_len_next;
                low_units_reg  <= low_units_next;
                cap_reg        <= cap_next;
                fall_stamp_reg <= fall_stamp_next;
            end
            if (s_fire && sym_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire && sym_valid) begin
            m_sym_reg   <= m_sym_next;
            m_start_reg <= m_start_next;
            m_end_reg   <= m_end_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_sym_reg;
    assign m_tdata  = {m_end_reg, m_start_reg};

endmodule

/* rtl/core/pwbsd_checker.sv */
`include "pulse_width_bit_symbol_decoder_core_defines.svh"

module pwbsd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pwbsd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [pwbsd_pkg::M_TUSER_W-1:0] m_tuser
);

    logic                                              m_stall;
    logic [pwbsd_pkg::M_TUSER_W+pwbsd_pkg::M_TDATA_W-1:0] m_word;

    assign m_stall = m_tvalid && !m_tready;
    assign m_word  = {m_tuser, m_tdata};

    // an empty output register never holds back a sample
    `PWBSD_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "s_tready low, output empty")

    // a waiting symbol that is not taken blocks the input
    `PWBSD_ASSERT_NOW(a_block_when_full, m_stall, !s_tready, "input not stalled")

    // a stalled symbol keeps its value
    `PWBSD_ASSERT_NEXT(a_hold_stalled, m_stall, m_tvalid && $stable(m_word), "symbol changed")

    // no symbol straight out of reset
    `PWBSD_ASSERT_RST(a_reset_clears, !aresetn, !m_tvalid, "m_tvalid high after reset")

endmodule

bind pulse_width_bit_symbol_decoder_core pwbsd_checker u_pwbsd_checker (.*);

/* test/tb_pulse_width_bit_symbol_decoder_core.sv */
`timescale 1ns / 1ps

module tb_pulse_width_bit_symbol_decoder_core;

    localparam int unsigned COUNT_MAX   = 65535;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } line_phase_t;

    typedef struct {
        logic        level;
        int unsigned gap;
    } line_item_t;

    typedef struct {
        pwbsd_pkg::symbol_t sym;
        logic [31:0]        start_at;
        logic [31:0]        end_at;
    } symbol_rec_t;

    // dut connections, all inputs known from time zero
    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [pwbsd_pkg::UNIT_W-1:0]    cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [pwbsd_pkg::S_TDATA_W-1:0] s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [pwbsd_pkg::M_TDATA_W-1:0] m_tdata;
    logic [pwbsd_pkg::M_TUSER_W-1:0] m_tuser;

    // line samples waiting to be sent and symbols waiting to come out
    line_item_t  line_q[$];
    symbol_rec_t pending_symbols[$];

    // decoder state as predicted
    logic [pwbsd_pkg::UNIT_W-1:0] unit_reg   = pwbsd_pkg::UNIT_RESET;
    logic [31:0]       smp_index  = '0;
    line_phase_t       dec_phase  = PH_WAIT;
    logic              prev_level = 1'b1;
    int unsigned       low_len    = 0;
    int unsigned       high_len   = 0;
    int unsigned       low_u      = 0;
    logic [31:0]       fall_at    = '0;
    logic [31:0]       rise_at    = '0;

    // stimulus and checking bookkeeping
    int unsigned gap_left     = 0;
    int unsigned cur_gap      = 0;
    int unsigned rx_wait      = 0;
    bit          rx_idle      = 1'b1;
    int unsigned hold_asked   = 0;
    int unsigned hold_given   = 0;
    int unsigned hold_left    = 0;
    int unsigned mismatches   = 0;
    int unsigned samples_sent = 0;
    int unsigned stall_cycles = 0;
    int unsigned unit_writes  = 0;
    int unsigned cycles       = 0;
    int unsigned seen [4]     = '{0, 0, 0, 0};

    pulse_width_bit_symbol_decoder_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned eff_unit();
        return (unit_reg == 0) ? 1 : int'(unit_reg);
    endfunction

    // nearest whole unit, ties to even, capped at seven
    function automatic int unsigned to_units(int unsigned len, int unsigned u);
        int unsigned q;
        int unsigned r;
        q = len / u;
        r = len % u;
        if (2 * r > u || (2 * r == u && q[0]))
            q++;
        return (q > 7) ? 7 : q;
    endfunction

    function automatic void start_low();
        fall_at   = smp_index;
        low_len   = 1;
        dec_phase = PH_LOW;
    endfunction

    // advance the predicted decoder by one line sample
    function automatic void decode_sample(logic lvl);
        int unsigned        u;
        int unsigned        cap;
        int unsigned        hu;
        logic [31:0]        stop;
        pwbsd_pkg::symbol_t sym;
        bit                 hit;
        u = eff_unit();
        case (dec_phase)
            PH_LOW: begin
                if (lvl) begin
                    low_u = to_units(low_len, u);
                    if (low_u >= 1 && low_u <= 3) begin
                        rise_at   = smp_index;
                        high_len  = 0;
                        dec_phase = PH_HIGH;
                    end else begin
                        dec_phase = PH_WAIT;
                    end
                end else if (low_len < COUNT_MAX) begin
                    low_len++;
                end
            end
            PH_HIGH: begin
                cap = (4 - low_u) * u;
                if (cap > COUNT_MAX)
                    cap = COUNT_MAX;
                if (high_len < COUNT_MAX)
                    high_len++;
                if (!lvl || high_len >= cap) begin
                    hu   = to_units(high_len, u);
                    stop = rise_at + 32'(high_len);
                    hit  = 1'b1;
                    sym  = pwbsd_pkg::SYM_ZERO;
                    if (low_u == 1 && hu == 3) begin
                        sym = pwbsd_pkg::SYM_ONE;
                    end else if (low_u == 3 && hu == 1) begin
                        sym = pwbsd_pkg::SYM_ZERO;
                    end else if (low_u == 1 && hu == 2) begin
                        sym = pwbsd_pkg::SYM_CONSOLE;
                    end else if (low_u == 2 && (hu == 1 || hu == 2)) begin
                        sym = pwbsd_pkg::SYM_CONTROLLER;
                        // two-by-two stop ends one unit early
                        if (hu == 2)
                            stop = stop - 32'(u);
                    end else begin
                        hit = 1'b0;
                    end
                    if (hit)
                        pending_symbols.push_back('{sym, fall_at, stop});
                    if (!lvl)
                        start_low();
                    else
                        dec_phase = PH_WAIT;
                end
            end
            default: begin
                if (prev_level && !lvl)
                    start_low();
                else
                    dec_phase = PH_WAIT;
            end
        endcase
        prev_level = lvl;
        smp_index  = smp_index + 32'd1;
    endfunction

    // sender: one queued sample per item, then the gap drawn for it
    always @(posedge aclk) begin
        line_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_sample(s_tdata[0]);
                samples_sent++;
                gap_left = cur_gap;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (line_q.size() != 0) begin
                    it = line_q.pop_front();
                    cur_gap = it.gap;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(pwbsd_pkg::S_TDATA_W-1){1'b0}}, it.level};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_given <= 0;
        end else if (hold_given != hold_asked) begin
            hold_left  <= HOLD_CYCLES;
            hold_given <= hold_asked;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: random wait before each item while rx_idle is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready)
                rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void flag_mismatch(string what, symbol_rec_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): exp sym %0d start %0d end %0d, got sym %0d start %0d end %0d",
                     what, want.sym, want.start_at, want.end_at,
                     m_tuser, m_tdata[31:0], m_tdata[63:32]);
    endfunction

    // result checker
    always @(posedge aclk) begin
        symbol_rec_t want;
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                stall_cycles++;
            if (m_tvalid && m_tready) begin
                if (pending_symbols.size() == 0) begin
                    want = '{pwbsd_pkg::SYM_ZERO, '0, '0};
                    flag_mismatch("nothing expected", want);
                end else begin
                    want = pending_symbols.pop_front();
                    if (m_tuser !== want.sym || m_tdata[31:0] !== want.start_at ||
                        m_tdata[63:32] !== want.end_at)
                        flag_mismatch("field", want);
                    seen[m_tuser]++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_run(logic lvl, int unsigned n, int unsigned gmax);
        int unsigned k;
        for (k = 0; k < n; k++)
            line_q.push_back('{lvl, $urandom_range(0, gmax)});
    endtask

    task automatic push_pulse(int unsigned lo, int unsigned hi, int unsigned gmax);
        push_run(1'b0, lo, gmax);
        push_run(1'b1, hi, gmax);
    endtask

    // nominal length with up to half a unit either way, ties included
    function automatic int unsigned spread(int unsigned nominal, int unsigned u);
        int unsigned v;
        v = nominal - u / 2 + $urandom_range(0, 2 * (u / 2));
        return (v < 1) ? 1 : v;
    endfunction

    task automatic drain_line();
        while (line_q.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    // bring the decoder back to waiting on an idle line, all results out
    task automatic settle_decoder();
        drain_line();
        while (dec_phase != PH_WAIT) begin
            push_run(1'b1, eff_unit(), 0);
            drain_line();
        end
        while (pending_symbols.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_unit(logic [pwbsd_pkg::UNIT_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        unit_reg = val;
        unit_writes++;
        repeat (2) @(negedge aclk);
    endtask

    // mostly well-formed symbols with jitter, some broken pulses and noise
    task automatic random_stretch(int unsigned pieces, bit gaps);
        int unsigned u;
        int unsigned p;
        int unsigned kind;
        int unsigned lu;
        int unsigned hu;
        int unsigned gmax;
        int unsigned k;
        u = eff_unit();
        for (p = 0; p < pieces; p++) begin
            gmax = (gaps && $urandom_range(0, 3) != 0) ? 19 : 0;
            kind = $urandom_range(0, 9);
            case ($urandom_range(0, 4))
                0: begin lu = 1; hu = 3; end
                1: begin lu = 3; hu = 1; end
                2: begin lu = 1; hu = 2; end
                3: begin lu = 2; hu = 1; end
                default: begin lu = 2; hu = 2; end
            endcase
            if (kind < 7) begin
                push_pulse(spread(lu * u, u), spread(hu * u, u), gmax);
            end else if (kind == 7) begin
                // high phase ended by the unit limit
                push_pulse(spread(lu * u, u), $urandom_range(4 * u, 6 * u), gmax);
            end else if (kind == 8) begin
                push_pulse($urandom_range(1, 5 * u), $urandom_range(1, 5 * u), gmax);
            end else begin
                for (k = $urandom_range(1, 8); k != 0; k--)
                    line_q.push_back('{1'($urandom_range(0, 1)), $urandom_range(0, gmax)});
            end
        end
    endtask

    initial begin
        // reset
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // line low straight after reset, one bit at the reset unit
        push_pulse(4, 13, 19);
        settle_decoder();

        // each symbol and a few rejects at one sample per unit
        write_unit(12'd1);
        push_pulse(1, 3, 19);
        push_pulse(3, 1, 19);
        push_pulse(1, 2, 19);
        push_pulse(2, 1, 19);
        push_pulse(2, 2, 19);
        push_pulse(4, 1, 19);
        push_pulse(1, 1, 19);
        push_pulse(1, 3, 19);
        settle_decoder();

        // random stretches over small units, zero among them
        write_unit(12'd0);
        rx_idle = 1'b1;
        random_stretch(16, 1);
        settle_decoder();
        write_unit(12'd2);
        rx_idle = 1'b0;
        random_stretch(12, 1);
        settle_decoder();
        write_unit(12'd3);
        rx_idle = 1'b1;
        random_stretch(6, 1);
        settle_decoder();
        write_unit(12'd5);
        random_stretch(3, 0);
        settle_decoder();
        write_unit(pwbsd_pkg::UNIT_RESET);
        rx_idle = ($urandom_range(0, 1) != 0);
        random_stretch(4, 1);
        settle_decoder();
        write_unit(12'($urandom_range(6, 12)));
        rx_idle = 1'b1;
        random_stretch(2, 1);
        settle_decoder();

        // widest unit, a short pulse rounds to no unit at all
        write_unit(12'hfff);
        push_pulse(3, 3, 0);
        settle_decoder();

        // receiver holds off while symbols keep coming, input backs up
        write_unit(12'd2);
        rx_idle = 1'b0;
        hold_asked++;
        random_stretch(10, 0);
        settle_decoder();

        repeat (8) @(negedge aclk);
        $display("sent %0d samples over %0d unit settings, %0d input stall cycles",
                 samples_sent, unit_writes, stall_cycles);
        $display("checked %0d zero, %0d one, %0d console stop, %0d controller stop symbols",
                 seen[pwbsd_pkg::SYM_ZERO], seen[pwbsd_pkg::SYM_ONE],
                 seen[pwbsd_pkg::SYM_CONSOLE], seen[pwbsd_pkg::SYM_CONTROLLER]);
        if (mismatches == 0 && pending_symbols.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d symbols never seen", mismatches,
                     pending_symbols.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pwbsd_pkg.sv
rtl/core/pulse_width_bit_symbol_decoder_core.sv
rtl/core/pwbsd_checker.sv
test/tb_pulse_width_bit_symbol_decoder_core.sv
